/* src/rqyc_pkg.sv */
// Shared types and constants for the read quality yield counter.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package rqyc_pkg;

  localparam int KIND_W     = 2;
  localparam int LEN_W      = 32;
  localparam int QUAL_W     = 8;
  localparam int ID_W       = 4;
  localparam int METRIC_W   = 64;
  localparam int IN_TDATA_W = 48;

  // Item kinds carried on the input tuser.
  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BASE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  // Input tdata bit positions.
  localparam int BIT_SECONDARY     = 0;
  localparam int BIT_SUPPLEMENTARY = 1;
  localparam int BIT_QC_FAILED     = 2;
  localparam int LEN_LSB           = 3;
  localparam int QUAL_LSB          = LEN_LSB + LEN_W;

  // Metric identifiers in report order.
  localparam logic [ID_W-1:0] M_TOTAL_READS   = 4'd0;
  localparam logic [ID_W-1:0] M_PF_READS      = 4'd1;
  localparam logic [ID_W-1:0] M_READ_LENGTH   = 4'd2;
  localparam logic [ID_W-1:0] M_TOTAL_BASES   = 4'd3;
  localparam logic [ID_W-1:0] M_PF_BASES      = 4'd4;
  localparam logic [ID_W-1:0] M_Q10_BASES     = 4'd5;
  localparam logic [ID_W-1:0] M_PF_Q10_BASES  = 4'd6;
  localparam logic [ID_W-1:0] M_Q20_BASES     = 4'd7;
  localparam logic [ID_W-1:0] M_PF_Q20_BASES  = 4'd8;
  localparam logic [ID_W-1:0] M_Q30_BASES     = 4'd9;
  localparam logic [ID_W-1:0] M_PF_Q30_BASES  = 4'd10;
  localparam logic [ID_W-1:0] M_Q40_BASES     = 4'd11;
  localparam logic [ID_W-1:0] M_PF_Q40_BASES  = 4'd12;
  localparam logic [ID_W-1:0] M_Q20_EQ_YIELD  = 4'd13;
  localparam logic [ID_W-1:0] M_PF_Q20_EQ     = 4'd14;

  localparam logic [QUAL_W-1:0] Q_THRESH_10 = 8'd10;
  localparam logic [QUAL_W-1:0] Q_THRESH_20 = 8'd20;
  localparam logic [QUAL_W-1:0] Q_THRESH_30 = 8'd30;
  localparam logic [QUAL_W-1:0] Q_THRESH_40 = 8'd40;

  localparam int QSUM_DIVISOR = 20;

  typedef struct packed {
    logic            hdr;
    logic            base;
    logic            div_start;
    logic            load;
    logic [ID_W-1:0] idx;
  } rqyc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_valid;
  } rqyc_status_t;

  // Metrics whose value comes out of the shared divider.
  function automatic logic needs_div(input logic [ID_W-1:0] id);
    return (id == M_READ_LENGTH) || (id == M_Q20_EQ_YIELD) || (id == M_PF_Q20_EQ);
  endfunction

endpackage

`default_nettype wire

/* src/rqyc_ctrl.sv */
// Controller state machine for the read quality yield counter.
// Depends on rqyc_pkg; drives the datapath through the command struct and reads its status struct.
`default_nettype none

module rqyc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [rqyc_pkg::KIND_W-1:0] kind,
  input  wire logic                  m_tready,
  input  wire rqyc_pkg::rqyc_status_t status,
  output rqyc_pkg::rqyc_cmd_t        cmd
);
  import rqyc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EMIT   = 4'b0010,
    ST_DSTART = 4'b0100,
    ST_DWAIT  = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [ID_W-1:0] idx, idx_next;
  logic            accept;
  logic            out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  // The output register can take a new word when empty or emptying now.
  assign out_free = !status.out_valid || m_tready;

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    cmd.hdr       = accept && (kind == KIND_HEADER);
    cmd.base      = accept && (kind == KIND_BASE);
    cmd.div_start = 1'b0;
    cmd.load      = 1'b0;
    cmd.idx       = idx;
    case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_REPORT)) begin
          idx_next   = M_TOTAL_READS;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load = 1'b1;
          if (idx == M_PF_Q20_EQ) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = needs_div(idx + 1'b1) ? ST_DSTART : ST_EMIT;
          end
        end
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!status.div_busy) begin
          state_next = ST_EMIT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

`default_nettype wire

/* src/rqyc_dp.sv */
// Datapath of the read quality yield counter: counters, shared divider, output word.
// Depends on rqyc_pkg; commanded by rqyc_ctrl.
`default_nettype none

module rqyc_dp #(
  parameter int COUNTER_WIDTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rqyc_pkg::IN_TDATA_W-1:0] in_data,
  input  wire rqyc_pkg::rqyc_cmd_t           cmd,
  output rqyc_pkg::rqyc_status_t             status,
  input  wire logic                          m_tready,
  output logic                               m_tvalid,
  output logic [rqyc_pkg::METRIC_W-1:0]      m_tdata,
  output logic [rqyc_pkg::ID_W-1:0]          m_tuser,
  output logic                               m_tlast
);
  import rqyc_pkg::*;

  localparam int CW    = COUNTER_WIDTH;
  localparam int CNT_W = $clog2(CW + 1);

  // Steps of the divide by 20, counted down to zero.
  localparam logic [CNT_W-1:0] STEP_FOLD4  = CNT_W'(7);
  localparam logic [CNT_W-1:0] STEP_FOLD8  = CNT_W'(6);
  localparam logic [CNT_W-1:0] STEP_FOLD16 = CNT_W'(5);
  localparam logic [CNT_W-1:0] STEP_FOLD32 = CNT_W'(4);
  localparam logic [CNT_W-1:0] STEP_SCALE  = CNT_W'(3);
  localparam logic [CNT_W-1:0] STEP_REM    = CNT_W'(2);
  localparam logic [CNT_W-1:0] STEP_FIX    = CNT_W'(1);
  localparam logic [CW-1:0]    REM_MAX     = CW'(QSUM_DIVISOR / 2 - 1);

  logic                    skip_read;
  logic                    read_passes;
  logic [CW-1:0]           reads, pf_read_cnt, bases, pf_base_cnt;
  logic [CW-1:0]           q10, pf_q10, q20, pf_q20, q30, pf_q30, q40, pf_q40;
  logic [CW-1:0]           qsum, pf_qsum;

  logic                    sec, sup, qcf;
  logic [LEN_W-1:0]        len;
  logic [QUAL_W-1:0]       qual;
  logic [CW-1:0]           len_ext, qual_ext;

  logic [CW-1:0]           div_quo, div_rem, div_den;
  logic [CNT_W-1:0]        div_cnt;
  logic                    div_const;
  logic                    const_div;
  logic [CW:0]             rem_sh, rem_diff;
  logic [CW-1:0]           num_sel;
  logic [CW-1:0]           metric;

  assign sec      = in_data[BIT_SECONDARY];
  assign sup      = in_data[BIT_SUPPLEMENTARY];
  assign qcf      = in_data[BIT_QC_FAILED];
  assign len      = in_data[LEN_LSB +: LEN_W];
  assign qual     = in_data[QUAL_LSB +: QUAL_W];
  assign len_ext  = CW'(len);
  assign qual_ext = CW'(qual);

  // Read state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_read   <= 1'b1;
      read_passes <= 1'b0;
      reads   <= '0;  pf_read_cnt <= '0;  bases  <= '0;  pf_base_cnt <= '0;
      q10     <= '0;  pf_q10      <= '0;  q20    <= '0;  pf_q20      <= '0;
      q30     <= '0;  pf_q30      <= '0;  q40    <= '0;  pf_q40      <= '0;
      qsum    <= '0;  pf_qsum     <= '0;
    end else if (cmd.hdr) begin
      if (sec || sup) begin
        skip_read   <= 1'b1;
        read_passes <= 1'b0;
      end else begin
        skip_read   <= 1'b0;
        read_passes <= !qcf;
        reads <= reads + 1'b1;
        bases <= bases + len_ext;
        if (!qcf) begin
          pf_read_cnt <= pf_read_cnt + 1'b1;
          pf_base_cnt <= pf_base_cnt + len_ext;
        end
      end
    end else if (cmd.base && !skip_read) begin
      qsum <= qsum + qual_ext;
      if (qual >= Q_THRESH_10) q10 <= q10 + 1'b1;
      if (qual >= Q_THRESH_20) q20 <= q20 + 1'b1;
      if (qual >= Q_THRESH_30) q30 <= q30 + 1'b1;
      if (qual >= Q_THRESH_40) q40 <= q40 + 1'b1;
      if (read_passes) begin
        pf_qsum <= pf_qsum + qual_ext;
        if (qual >= Q_THRESH_10) pf_q10 <= pf_q10 + 1'b1;
        if (qual >= Q_THRESH_20) pf_q20 <= pf_q20 + 1'b1;
        if (qual >= Q_THRESH_30) pf_q30 <= pf_q30 + 1'b1;
        if (qual >= Q_THRESH_40) pf_q40 <= pf_q40 + 1'b1;
      end
    end
  end

  // Dividend chosen by the metric being reported.
  always_comb begin
    case (cmd.idx)
      M_READ_LENGTH:  num_sel = bases;
      M_Q20_EQ_YIELD: num_sel = qsum;
      default:        num_sel = pf_qsum;
    endcase
  end

  // The equivalent yields divide by the constant 20; only the mean length needs the
  // restoring divider.
  assign const_div = (cmd.idx != M_READ_LENGTH);

  assign rem_sh   = {div_rem, div_quo[CW-1]};
  assign rem_diff = rem_sh - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= const_div ? STEP_FOLD4 : CNT_W'(CW);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // Restoring mode yields one quotient bit per cycle. Constant mode keeps n = x / 2 in
  // div_den and builds 0.8 n by folding shifted copies, so that n / 10 is within one of
  // the estimate after the final scale; the remainder step then corrects it.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_const <= const_div;
      div_rem   <= '0;
      if (const_div) begin
        div_quo <= (num_sel >> 2) + (num_sel >> 3);
        div_den <= num_sel >> 1;
      end else begin
        div_quo <= num_sel;
        div_den <= reads;
      end
    end else if (div_cnt != '0) begin
      if (div_const) begin
        case (div_cnt)
          STEP_FOLD4:  div_quo <= div_quo + (div_quo >> 4);
          STEP_FOLD8:  div_quo <= div_quo + (div_quo >> 8);
          STEP_FOLD16: div_quo <= div_quo + (div_quo >> 16);
          STEP_FOLD32: div_quo <= div_quo + (div_quo >> 32);
          STEP_SCALE:  div_quo <= div_quo >> 3;
          STEP_REM:    div_rem <= div_den - (div_quo << 3) - (div_quo << 1);
          STEP_FIX:    div_quo <= div_quo + CW'(div_rem > REM_MAX);
          default:     ;
        endcase
      end else if (!rem_diff[CW]) begin
        div_rem <= rem_diff[CW-1:0];
        div_quo <= {div_quo[CW-2:0], 1'b1};
      end else begin
        div_rem <= rem_sh[CW-1:0];
        div_quo <= {div_quo[CW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    case (cmd.idx)
      M_TOTAL_READS:  metric = reads;
      M_PF_READS:     metric = pf_read_cnt;
      M_READ_LENGTH:  metric = (reads == '0) ? '0 : div_quo;
      M_TOTAL_BASES:  metric = bases;
      M_PF_BASES:     metric = pf_base_cnt;
      M_Q10_BASES:    metric = q10;
      M_PF_Q10_BASES: metric = pf_q10;
      M_Q20_BASES:    metric = q20;
      M_PF_Q20_BASES: metric = pf_q20;
      M_Q30_BASES:    metric = q30;
      M_PF_Q30_BASES: metric = pf_q30;
      M_Q40_BASES:    metric = q40;
      M_PF_Q40_BASES: metric = pf_q40;
      default:        metric = div_quo;
    endcase
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= METRIC_W'(metric);
      m_tuser <= cmd.idx;
      m_tlast <= (cmd.idx == M_PF_Q20_EQ);
    end
  end

  assign status.div_busy  = (div_cnt != '0);
  assign status.out_valid = m_tvalid;

endmodule

`default_nettype wire

/* src/read_quality_yield_counter.sv */
// Read quality yield counter: header and base words update counters at acceptance,
// one word per cycle. A report word closes the input and loads its fifteen metric words
// one per cycle from the next cycle on while the output is free; the mean read length
// also waits for the serial divider and each equivalent yield for the divide by 20.
// Synchronous reset clears all counters at once; no clearing pass is needed.
`default_nettype none

module read_quality_yield_counter #(
  parameter int COUNTER_WIDTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // tdata: secondary, supplementary, qc_failed, length[31:0], base_quality[7:0]
  input  wire logic [rqyc_pkg::IN_TDATA_W-1:0] s_tdata,
  // tuser: kind[1:0]
  input  wire logic [rqyc_pkg::KIND_W-1:0]     s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // tdata: metric_value[63:0]
  output logic [rqyc_pkg::METRIC_W-1:0]        m_tdata,
  // tuser: metric_id[3:0]
  output logic [rqyc_pkg::ID_W-1:0]            m_tuser,
  output logic                                 m_tlast
);
  import rqyc_pkg::*;

  rqyc_cmd_t    cmd;
  rqyc_status_t status;

  rqyc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rqyc_dp #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

/* src/rqyc_checker.sv */
// Port-level checks for the read quality yield counter, bound to the top level.
// Depends on rqyc_pkg for field widths and codes.
`default_nettype none

module rqyc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [rqyc_pkg::KIND_W-1:0]     s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [rqyc_pkg::METRIC_W-1:0]   m_tdata,
  input wire logic [rqyc_pkg::ID_W-1:0]       m_tuser,
  input wire logic                            m_tlast
);
  import rqyc_pkg::*;

  // Accepting a report word closes the input.
  a_report_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_REPORT) |=> !s_tready)
    else $error("input still ready right after a report word");

  // Mid-report words keep the input closed.
  a_mid_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready while a report is in progress");

  // The second metric follows the first without a gap.
  a_first_follow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tuser == M_TOTAL_READS) |=>
      m_tvalid && (m_tuser == M_PF_READS))
    else $error("second metric did not follow the first");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

endmodule

bind read_quality_yield_counter rqyc_checker u_rqyc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for read_quality_yield_counter: a directed table, then random reads.
// Needs rqyc_pkg and the block's RTL; results are checked against an in-bench yield model.
`timescale 1ns / 100ps

module tb;
  import rqyc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_WAIT = 17;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_WORDS = 190;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              sec;
    logic              sup;
    logic              qcf;
    logic [LEN_W-1:0]  len;
    logic [QUAL_W-1:0] qual;
  } word_in_t;

  typedef struct packed {
    word_in_t w;
    logic     all_zero;
  } stim_row_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [METRIC_W-1:0] value;
    logic                last;
  } metric_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [METRIC_W-1:0] m_tdata;
  logic [ID_W-1:0] m_tuser;
  logic m_tlast;

  // Yield model state.
  logic skip_read = 1'b1;
  logic read_passes = 1'b0;
  logic [METRIC_W-1:0] tot_reads = '0, pf_read_cnt = '0, tot_bases = '0, pf_base_cnt = '0;
  logic [METRIC_W-1:0] qsum_all = '0, qsum_pf = '0;
  // Threshold counters, index 0 for Q10 up to index 3 for Q40.
  logic [METRIC_W-1:0] qge_all [4] = '{default: '0};
  logic [METRIC_W-1:0] qge_pf [4] = '{default: '0};

  metric_word_t pending_metrics[$];
  int mismatches = 0;
  int sent_count = 0;
  int got_count = 0;

  read_quality_yield_counter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  task automatic flag_error(input string msg);
    mismatches++;
    $display("ERROR %0t ns: %s", $time, msg);
  endtask

  // Every third stretch of 32 words is sent or taken without random waits.
  function automatic int draw_wait(input int n);
    if ((n / 32) % 3 == 1) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [METRIC_W-1:0] metric_now(input logic [ID_W-1:0] id);
    case (id)
      M_TOTAL_READS:  return tot_reads;
      M_PF_READS:     return pf_read_cnt;
      M_READ_LENGTH:  return (tot_reads == 0) ? '0 : tot_bases / tot_reads;
      M_TOTAL_BASES:  return tot_bases;
      M_PF_BASES:     return pf_base_cnt;
      M_Q10_BASES:    return qge_all[0];
      M_PF_Q10_BASES: return qge_pf[0];
      M_Q20_BASES:    return qge_all[1];
      M_PF_Q20_BASES: return qge_pf[1];
      M_Q30_BASES:    return qge_all[2];
      M_PF_Q30_BASES: return qge_pf[2];
      M_Q40_BASES:    return qge_all[3];
      M_PF_Q40_BASES: return qge_pf[3];
      M_Q20_EQ_YIELD: return qsum_all / QSUM_DIVISOR;
      M_PF_Q20_EQ:    return qsum_pf / QSUM_DIVISOR;
      default:        return '0;
    endcase
  endfunction

  task automatic update_yield(input word_in_t w);
    metric_word_t mw;
    int level;
    case (w.kind)
      KIND_HEADER: begin
        if (w.sec || w.sup) begin
          skip_read = 1'b1;
          read_passes = 1'b0;
        end else begin
          skip_read = 1'b0;
          read_passes = !w.qcf;
          tot_reads = tot_reads + 1;
          tot_bases = tot_bases + w.len;
          if (read_passes) begin
            pf_read_cnt = pf_read_cnt + 1;
            pf_base_cnt = pf_base_cnt + w.len;
          end
        end
      end
      KIND_BASE: begin
        if (!skip_read) begin
          level = (w.qual >= Q_THRESH_40) ? 4 : (w.qual >= Q_THRESH_30) ? 3 :
                  (w.qual >= Q_THRESH_20) ? 2 : (w.qual >= Q_THRESH_10) ? 1 : 0;
          qsum_all = qsum_all + w.qual;
          if (read_passes) qsum_pf = qsum_pf + w.qual;
          for (int k = 0; k < level; k++) begin
            qge_all[k] = qge_all[k] + 1;
            if (read_passes) qge_pf[k] = qge_pf[k] + 1;
          end
        end
      end
      KIND_REPORT: begin
        for (int i = 0; i <= M_PF_Q20_EQ; i++) begin
          mw.id = ID_W'(i);
          mw.value = metric_now(mw.id);
          mw.last = (mw.id == M_PF_Q20_EQ);
          pending_metrics.push_back(mw);
        end
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input word_in_t w, input logic all_zero);
    logic [IN_TDATA_W-1:0] d;
    metric_word_t mw;
    int gap;
    d = '0;
    d[BIT_SECONDARY] = w.sec;
    d[BIT_SUPPLEMENTARY] = w.sup;
    d[BIT_QC_FAILED] = w.qcf;
    d[LEN_LSB +: LEN_W] = w.len;
    d[QUAL_LSB +: QUAL_W] = w.qual;
    gap = draw_wait(sent_count);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= w.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
    if (all_zero && w.kind == KIND_REPORT) begin
      for (int i = 0; i <= M_PF_Q20_EQ; i++) begin
        mw.id = ID_W'(i);
        mw.value = '0;
        mw.last = (mw.id == M_PF_Q20_EQ);
        pending_metrics.push_back(mw);
      end
    end else begin
      update_yield(w);
    end
    @(negedge clk);
  endtask

  function automatic stim_row_t row(input logic [KIND_W-1:0] kind, input logic sec,
                                    input logic sup, input logic qcf,
                                    input logic [LEN_W-1:0] len,
                                    input logic [QUAL_W-1:0] qual, input logic all_zero);
    stim_row_t r;
    r.w.kind = kind;
    r.w.sec = sec;
    r.w.sup = sup;
    r.w.qcf = qcf;
    r.w.len = len;
    r.w.qual = qual;
    r.all_zero = all_zero;
    return r;
  endfunction

  function automatic word_in_t rand_word(input logic [KIND_W-1:0] kind);
    word_in_t w;
    w.kind = kind;
    w.sec = 1'($urandom_range(0, 1));
    w.sup = 1'($urandom_range(0, 1));
    w.qcf = 1'($urandom_range(0, 1));
    w.len = $urandom;
    w.qual = QUAL_W'($urandom_range(0, 255));
    return w;
  endfunction

  // Result side: random stalls, each accepted word is checked against the oldest prediction.
  initial begin
    metric_word_t exp_w;
    int gap;
    while (rst) @(negedge clk);
    forever begin
      gap = draw_wait(got_count);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got_count++;
      if (pending_metrics.size() == 0) begin
        flag_error($sformatf("unexpected metric word id %0d value %0d", m_tuser, m_tdata));
      end else begin
        exp_w = pending_metrics.pop_front();
        if (m_tuser !== exp_w.id)
          flag_error($sformatf("metric id %0d, expected %0d", m_tuser, exp_w.id));
        if (m_tdata !== exp_w.value)
          flag_error($sformatf("metric %0d value %0d, expected %0d", exp_w.id, m_tdata,
                               exp_w.value));
        if (m_tlast !== exp_w.last)
          flag_error($sformatf("metric %0d last %b, expected %b", exp_w.id, m_tlast,
                               exp_w.last));
      end
      @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    stim_row_t directed_rows[$];
    word_in_t w;
    int counted;
    int pick;
    int nbases;

    // Reports marked all-zero must read back zero in every metric.
    directed_rows = {
      row(KIND_REPORT, 1'b0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b1),
      row(KIND_BASE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'd255, 1'b0),   // base before any header
      row(KIND_HEADER, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF, 8'd0, 1'b0),   // secondary
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd40, 1'b0),
      row(KIND_HEADER, 1'b0, 1'b1, 1'b0, 32'd5, 8'd0, 1'b0),           // supplementary
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd30, 1'b0),
      row(KIND_UNUSED, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'd255, 1'b0),
      row(KIND_REPORT, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'd255, 1'b1),
      row(KIND_HEADER, 1'b0, 1'b0, 1'b0, 32'd0, 8'd255, 1'b0),   // bases differ from length
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0),
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd9, 1'b0),
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd10, 1'b0),
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd19, 1'b0),
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd20, 1'b0),
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd30, 1'b0),
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd40, 1'b0),
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd255, 1'b0),
      row(KIND_HEADER, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'd0, 1'b0),   // QC-failed
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd29, 1'b0),
      row(KIND_BASE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'd255, 1'b0),
      row(KIND_HEADER, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 8'd0, 1'b0),
      row(KIND_BASE, 1'b0, 1'b0, 1'b0, 32'd0, 8'd39, 1'b0),
      row(KIND_REPORT, 1'b0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0),
      row(KIND_HEADER, 1'b1, 1'b1, 1'b1, 32'd7, 8'd0, 1'b0),
      row(KIND_REPORT, 1'b0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) send_word(directed_rows[i].w, directed_rows[i].all_zero);

    // Mostly whole reads with random content; reports and stray words now and then.
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        send_word(rand_word(KIND_REPORT), 1'b0);
        counted++;
      end else if (pick < 10) begin
        send_word(rand_word(KIND_UNUSED), 1'b0);
      end else if (pick < 14) begin
        send_word(rand_word(KIND_W'($urandom_range(0, 1))), 1'b0);
        counted++;
      end else begin
        w = rand_word(KIND_HEADER);
        w.sec = ($urandom_range(0, 7) == 0);
        w.sup = ($urandom_range(0, 7) == 0);
        w.qcf = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 7);
        if (pick == 0) w.len = 32'hFFFF_FFFF;
        else if (pick > 1) w.len = $urandom_range(0, 300);
        send_word(w, 1'b0);
        counted++;
        nbases = $urandom_range(0, 10);
        for (int b = 0; b < nbases; b++) begin
          w = rand_word(KIND_BASE);
          if ($urandom_range(0, 3) != 0) w.qual = QUAL_W'($urandom_range(0, 45));
          send_word(w, 1'b0);
          counted++;
        end
      end
    end
    send_word(rand_word(KIND_REPORT), 1'b0);
    s_tvalid <= 1'b0;

    while (pending_metrics.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/rqyc_pkg.sv
src/rqyc_ctrl.sv
src/rqyc_dp.sv
src/read_quality_yield_counter.sv
src/rqyc_checker.sv
tb/tb.sv
